/* rtl/fba_pkg.sv */
`timescale 1ns / 1ps

package fba_pkg;

    localparam int DEF_DISK_BLOCKS     = 128;
    localparam int DEF_TABLE_ENTRIES   = 16;
    localparam int DEF_MAX_FILE_BLOCKS = 8;

    localparam int REQ_TYPE_W    = 2;
    localparam int NAME_W        = 64;
    localparam int FILE_BLOCKS_W = 4;
    localparam int BLOCK_INDEX_W = 3;
    localparam int STATUS_W      = 3;
    localparam int DISK_BLOCK_W  = 7;
    localparam int ENTRY_SLOT_W  = 4;

    localparam logic [REQ_TYPE_W-1:0] REQ_CREATE    = 2'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_DELETE    = 2'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_TRANSLATE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NO_BLOCKS = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_ENTRY  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd4;

    // bytes after the first zero byte read as zero
    function automatic logic [NAME_W-1:0] norm_name(input logic [NAME_W-1:0] n);
        logic [NAME_W-1:0] res;
        logic              alive;
        res   = '0;
        alive = 1'b1;
        for (int b = 0; b < NAME_W / 8; b++)
        begin
            alive = alive && (n[8*b +: 8] != 8'd0);
            if (alive)
            begin
                res[8*b +: 8] = n[8*b +: 8];
            end
        end
        return res;
    endfunction

endpackage

/* rtl/fba_if.sv */
`timescale 1ns / 1ps

interface fba_req_if
    import fba_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [REQ_TYPE_W-1:0]    req_type;
    logic [NAME_W-1:0]        file_name;
    logic [FILE_BLOCKS_W-1:0] file_blocks;
    logic [BLOCK_INDEX_W-1:0] block_index;

    modport source (output valid, req_type, file_name, file_blocks, block_index,
                    input ready);
    modport sink   (input valid, req_type, file_name, file_blocks, block_index,
                    output ready);
endinterface

interface fba_resp_if
    import fba_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [STATUS_W-1:0]     status;
    logic [DISK_BLOCK_W-1:0] disk_block;
    logic [ENTRY_SLOT_W-1:0] entry_slot;

    modport source (output valid, status, disk_block, entry_slot, input ready);
    modport sink   (input valid, status, disk_block, entry_slot, output ready);
endinterface

/* rtl/file_block_allocator_core.sv */
`timescale 1ns / 1ps
// Flow: create scans the bitmap for free blocks, then the entries, then writes pointers;
//          delete finds the entry and frees its blocks; translate reads one pointer.
// Throughput: one request at a time, ready only when idle; the single-port bitmap,
//          name and pointer memories are probed one entry per step.
// Reset: rst_n async, clears control and entry valid bits, then a bitmap clearing
//          pass over all DISK_BLOCKS entries runs before the first request is taken.
module file_block_allocator_core
    import fba_pkg::*;
#(
    parameter int DISK_BLOCKS     = DEF_DISK_BLOCKS,
    parameter int TABLE_ENTRIES   = DEF_TABLE_ENTRIES,
    parameter int MAX_FILE_BLOCKS = DEF_MAX_FILE_BLOCKS
)
(
    input  logic        clk,
    input  logic        rst_n,
    fba_req_if.sink     req,
    fba_resp_if.source  resp
);

    localparam int BLK_W = $clog2(DISK_BLOCKS);
    localparam int ENT_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(MAX_FILE_BLOCKS + 1);
    localparam int PI_W  = (MAX_FILE_BLOCKS > 1) ? $clog2(MAX_FILE_BLOCKS) : 1;
    localparam int PT_DEPTH = TABLE_ENTRIES * MAX_FILE_BLOCKS;
    localparam int PA_W  = $clog2(PT_DEPTH);
    localparam int ROW_W = NAME_W + CNT_W;

    localparam logic [PA_W-1:0]  MFB_P    = PA_W'(MAX_FILE_BLOCKS);
    localparam logic [BLK_W-1:0] BLK_LAST = BLK_W'(DISK_BLOCKS - 1);
    localparam logic [ENT_W-1:0] ENT_LAST = ENT_W'(TABLE_ENTRIES - 1);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_BRD, S_BCHK, S_ESCAN, S_WR,
        S_FRD, S_FCHK, S_DRD, S_DWR, S_TRD, S_TWT, S_RESP
    } state_t;

    state_t                  state_reg;
    logic [REQ_TYPE_W-1:0]   req_reg;
    logic [NAME_W-1:0]       name_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [BLOCK_INDEX_W-1:0] idx_reg;
    logic [BLK_W-1:0]        scan_reg;
    logic [CNT_W-1:0]        nf_reg;
    logic [BLK_W-1:0]        found_reg [MAX_FILE_BLOCKS];
    logic [ENT_W-1:0]        ent_reg;
    logic [CNT_W-1:0]        wi_reg;
    logic [CNT_W-1:0]        len_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [STATUS_W-1:0]     res_status_reg;
    logic [BLK_W-1:0]        res_blk_reg;
    logic [ENT_W-1:0]        res_slot_reg;
    logic                    out_vld_reg;
    logic [STATUS_W-1:0]     out_status_reg;
    logic [BLK_W-1:0]        out_blk_reg;
    logic [ENT_W-1:0]        out_slot_reg;

    logic                    bm_mem [DISK_BLOCKS];
    logic [ROW_W-1:0]        nm_mem [TABLE_ENTRIES];
    logic [BLK_W-1:0]        pt_mem [PT_DEPTH];
    logic                    bm_rdata_reg;
    logic [ROW_W-1:0]        nm_rdata_reg;
    logic [BLK_W-1:0]        pt_rdata_reg;

    logic                    bm_we, bm_re, bm_wdata;
    logic [BLK_W-1:0]        bm_addr;
    logic                    nm_we, nm_re;
    logic                    pt_we, pt_re;
    logic [PA_W-1:0]         pt_addr;
    logic [BLK_W-1:0]        wr_blk;
    logic                    hit;
    logic [CNT_W-1:0]        nf_inc;
    logic [NAME_W-1:0]       row_name;
    logic [CNT_W-1:0]        row_len;
    logic                    row_match;
    logic                    out_free;

    assign wr_blk    = found_reg[wi_reg[PI_W-1:0]];
    assign hit       = !bm_rdata_reg;
    assign nf_inc    = nf_reg + CNT_W'(hit);
    assign row_name  = nm_rdata_reg[NAME_W-1:0];
    assign row_len   = nm_rdata_reg[NAME_W +: CNT_W];
    assign row_match = valid_reg[ent_reg] && (row_name == name_reg);
    assign out_free  = !out_vld_reg || resp.ready;

    always_comb
    begin
        bm_we    = 1'b0;
        bm_re    = 1'b0;
        bm_wdata = 1'b0;
        bm_addr  = scan_reg;
        unique case (state_reg)
            S_CLR:
            begin
                bm_we = 1'b1;
            end
            S_BRD:
            begin
                bm_re = 1'b1;
            end
            S_WR:
            begin
                bm_we    = (wi_reg != cnt_reg);
                bm_wdata = 1'b1;
                bm_addr  = wr_blk;
            end
            S_DWR:
            begin
                bm_we   = 1'b1;
                bm_addr = pt_rdata_reg;
            end
            default:
            begin
                bm_we = 1'b0;
            end
        endcase
    end

    assign nm_we   = (state_reg == S_ESCAN) && !valid_reg[ent_reg];
    assign nm_re   = (state_reg == S_FRD);
    assign pt_we   = (state_reg == S_WR) && (wi_reg != cnt_reg);
    assign pt_re   = ((state_reg == S_DRD) && (wi_reg != len_reg)) || (state_reg == S_TRD);
    assign pt_addr = PA_W'(ent_reg) * MFB_P
                   + ((state_reg == S_TRD) ? PA_W'(idx_reg) : PA_W'(wi_reg));

    always_ff @(posedge clk)
    begin
        if (bm_we)
        begin
            bm_mem[bm_addr] <= bm_wdata;
        end
        if (bm_re)
        begin
            bm_rdata_reg <= bm_mem[bm_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (nm_we)
        begin
            nm_mem[ent_reg] <= {cnt_reg, name_reg};
        end
        if (nm_re)
        begin
            nm_rdata_reg <= nm_mem[ent_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pt_we)
        begin
            pt_mem[pt_addr] <= wr_blk;
        end
        if (pt_re)
        begin
            pt_rdata_reg <= pt_mem[pt_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLR;
            scan_reg    <= '0;
            valid_reg   <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (out_vld_reg && resp.ready && (state_reg != S_RESP))
            begin
                out_vld_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLR:
                begin
                    scan_reg <= scan_reg + 1'b1;
                    if (scan_reg == BLK_LAST)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        req_reg        <= req.req_type;
                        name_reg       <= norm_name(req.file_name);
                        cnt_reg        <= CNT_W'(req.file_blocks);
                        idx_reg        <= req.block_index;
                        res_status_reg <= ST_OK;
                        res_blk_reg    <= '0;
                        res_slot_reg   <= '0;
                        scan_reg       <= BLK_W'(1);
                        nf_reg         <= '0;
                        ent_reg        <= '0;
                        wi_reg         <= '0;
                        unique case (req.req_type) inside
                            REQ_CREATE:
                            begin
                                if (32'(req.file_blocks) > MAX_FILE_BLOCKS)
                                begin
                                    res_status_reg <= ST_RANGE;
                                    state_reg      <= S_RESP;
                                end
                                else if (req.file_blocks == '0)
                                begin
                                    state_reg <= S_ESCAN;
                                end
                                else
                                begin
                                    state_reg <= S_BRD;
                                end
                            end
                            REQ_DELETE, REQ_TRANSLATE:
                            begin
                                state_reg <= S_FRD;
                            end
                            default:
                            begin
                                state_reg <= S_RESP;
                            end
                        endcase
                    end
                end
                S_BRD:
                begin
                    state_reg <= S_BCHK;
                end
                S_BCHK:
                begin
                    if (hit)
                    begin
                        found_reg[nf_reg[PI_W-1:0]] <= scan_reg;
                    end
                    nf_reg <= nf_inc;
                    if (nf_inc == cnt_reg)
                    begin
                        state_reg <= S_ESCAN;
                    end
                    else if (scan_reg == BLK_LAST)
                    begin
                        res_status_reg <= ST_NO_BLOCKS;
                        state_reg      <= S_RESP;
                    end
                    else
                    begin
                        scan_reg  <= scan_reg + 1'b1;
                        state_reg <= S_BRD;
                    end
                end
                S_ESCAN:
                begin
                    if (!valid_reg[ent_reg])
                    begin
                        valid_reg[ent_reg] <= 1'b1;
                        res_slot_reg       <= ent_reg;
                        state_reg          <= S_WR;
                    end
                    else if (ent_reg == ENT_LAST)
                    begin
                        res_status_reg <= ST_NO_ENTRY;
                        state_reg      <= S_RESP;
                    end
                    else
                    begin
                        ent_reg <= ent_reg + 1'b1;
                    end
                end
                S_WR:
                begin
                    if (wi_reg == cnt_reg)
                    begin
                        state_reg <= S_RESP;
                    end
                    else
                    begin
                        wi_reg <= wi_reg + 1'b1;
                    end
                end
                S_FRD:
                begin
                    state_reg <= S_FCHK;
                end
                S_FCHK:
                begin
                    if (row_match)
                    begin
                        len_reg <= row_len;
                        if (req_reg == REQ_DELETE)
                        begin
                            state_reg <= S_DRD;
                        end
                        else if (32'(idx_reg) >= 32'(row_len)
                                 || 32'(idx_reg) >= MAX_FILE_BLOCKS)
                        begin
                            res_status_reg <= ST_RANGE;
                            state_reg      <= S_RESP;
                        end
                        else
                        begin
                            state_reg <= S_TRD;
                        end
                    end
                    else if (ent_reg == ENT_LAST)
                    begin
                        res_status_reg <= ST_NOT_FOUND;
                        state_reg      <= S_RESP;
                    end
                    else
                    begin
                        ent_reg   <= ent_reg + 1'b1;
                        state_reg <= S_FRD;
                    end
                end
                S_DRD:
                begin
                    if (wi_reg == len_reg)
                    begin
                        valid_reg[ent_reg] <= 1'b0;
                        res_slot_reg       <= ent_reg;
                        state_reg          <= S_RESP;
                    end
                    else
                    begin
                        state_reg <= S_DWR;
                    end
                end
                S_DWR:
                begin
                    wi_reg    <= wi_reg + 1'b1;
                    state_reg <= S_DRD;
                end
                S_TRD:
                begin
                    state_reg <= S_TWT;
                end
                S_TWT:
                begin
                    res_blk_reg  <= pt_rdata_reg;
                    res_slot_reg <= ent_reg;
                    state_reg    <= S_RESP;
                end
                S_RESP:
                begin
                    if (out_free)
                    begin
                        out_vld_reg    <= 1'b1;
                        out_status_reg <= res_status_reg;
                        out_blk_reg    <= res_blk_reg;
                        out_slot_reg   <= res_slot_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign req.ready       = (state_reg == S_IDLE);
    assign resp.valid      = out_vld_reg;
    assign resp.status     = out_status_reg;
    assign resp.disk_block = DISK_BLOCK_W'(out_blk_reg);
    assign resp.entry_slot = ENTRY_SLOT_W'(out_slot_reg);

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request taken while busy");

    a_block0_reserved: assert property (@(posedge clk) disable iff (!rst_n)
        bm_we && bm_wdata |-> bm_addr != '0)
        else $error("reserved block marked in use");

    a_scan_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_BCHK |-> nf_reg < cnt_reg)
        else $error("bitmap scan past requested count");

    a_create_valid: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RESP && req_reg == REQ_CREATE && res_status_reg == ST_OK
        |-> valid_reg[res_slot_reg])
        else $error("created entry not valid");

    a_delete_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RESP && req_reg == REQ_DELETE && res_status_reg == ST_OK
        |-> !valid_reg[res_slot_reg])
        else $error("deleted entry still valid");
`endif

endmodule
